@@ design/imu_cf_pkg.sv @@
// Shared constants, register indexes and control types for the IMU axis
// conditioning filter. No dependencies; every other design file imports it.
package imu_cf_pkg;

  localparam int TS_W       = 32;
  localparam int RAW_W      = 16;
  localparam int OUT_W      = 32;
  localparam int TAU_W      = 32;
  localparam int SCALE_W    = 24;
  localparam int OFFS_W     = 32;
  localparam int GAIN_W     = 24;
  localparam int ALPHA_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  // Serial multiplier operand widths: multiplicand holds the exact 34-bit
  // offset sum, multiplier holds a 25-bit signed digit string.
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 25;

  localparam int OVERLOAD_LIMIT_DEF = 32000;

  localparam logic [TAU_W-1:0]   TAU_RST   = TAU_W'(10000);
  localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(511501);
  localparam logic [GAIN_W-1:0]  GAIN_RST  = GAIN_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_TAU      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCALE    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Z = CFG_IDX_W'(4);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_X   = CFG_IDX_W'(5);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Y   = CFG_IDX_W'(6);
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Z   = CFG_IDX_W'(7);

  typedef struct packed {
    logic start;     // begin one item
    logic alpha_ok;  // filter coefficient is ready
    logic ack;       // result taken, return to idle
  } lane_ctrl_t;

endpackage

@@ design/imu_cf_if.sv @@
// Stream and configuration channel interfaces for the IMU conditioning filter.
// Depends on imu_cf_pkg for field widths.
interface imu_cf_in_if;
  import imu_cf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [TS_W-1:0]         timestamp_us;
  logic signed [RAW_W-1:0] raw_x;
  logic signed [RAW_W-1:0] raw_y;
  logic signed [RAW_W-1:0] raw_z;
  modport source(output valid, timestamp_us, raw_x, raw_y, raw_z, input ready);
  modport sink(input valid, timestamp_us, raw_x, raw_y, raw_z, output ready);
endinterface

interface imu_cf_out_if;
  import imu_cf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] filtered_out_x;
  logic signed [OUT_W-1:0] filtered_out_y;
  logic signed [OUT_W-1:0] filtered_out_z;
  logic                    overload;
  modport source(output valid, filtered_out_x, filtered_out_y, filtered_out_z, overload,
                 input ready);
  modport sink(input valid, filtered_out_x, filtered_out_y, filtered_out_z, overload,
               output ready);
endinterface

interface imu_cf_cfg_if;
  import imu_cf_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

@@ design/imu_cf_mul.sv @@
// Bit-serial signed multiplier: one multiplier bit per cycle, sign bit weighted
// negative. Uses imu_cf_pkg for default operand widths.
module imu_cf_mul #(
  parameter int A_W = imu_cf_pkg::MUL_A_W,
  parameter int B_W = imu_cf_pkg::MUL_B_W
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [A_W-1:0]   a,
  input  logic signed [B_W-1:0]   b,
  output logic                    done,
  output logic signed [A_W+B_W-1:0] p
);
  import imu_cf_pkg::*;

  localparam int P_W   = A_W + B_W;
  localparam int CNT_W = (B_W > 1) ? $clog2(B_W) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(B_W - 1);

  logic                   busy;
  logic [CNT_W-1:0]       cnt;
  logic signed [P_W-1:0]  mcand;
  logic [B_W-1:0]         mplier;
  logic signed [P_W-1:0]  acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      if (start) begin
        busy   <= 1'b1;
        done   <= 1'b0;
        cnt    <= '0;
        mcand  <= P_W'(a);
        mplier <= b;
        acc    <= '0;
      end else if (busy) begin
        // the top multiplier bit carries negative weight
        if (mplier[0]) begin
          acc <= (cnt == CNT_LAST) ? acc - mcand : acc + mcand;
        end
        mcand  <= mcand <<< 1;
        mplier <= mplier >> 1;
        cnt    <= cnt + CNT_W'(1);
        done   <= (cnt == CNT_LAST);
        if (cnt == CNT_LAST) begin
          busy <= 1'b0;
        end
      end else begin
        done <= 1'b0;
      end
    end
  end

  assign p = acc;

endmodule

@@ design/imu_cf_div.sv @@
// Restoring divider for the filter coefficient alpha = floor(dt*2^16/(tau+dt)),
// with a zero tau taken as one; one quotient bit per cycle. Uses imu_cf_pkg widths.
module imu_cf_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [imu_cf_pkg::TS_W-1:0]   dt,
  input  logic [imu_cf_pkg::TAU_W-1:0]  tau,
  output logic                          valid,
  output logic [imu_cf_pkg::ALPHA_W-1:0] alpha
);
  import imu_cf_pkg::*;

  localparam int D_W   = TAU_W + 1;
  localparam int CNT_W = $clog2(ALPHA_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ALPHA_W - 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [D_W-1:0]   divisor;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     rem2;
  logic             fits;
  logic [TAU_W-1:0] tau_eff;

  assign tau_eff = (tau == '0) ? TAU_W'(1) : tau;
  assign rem2    = {rem, 1'b0};
  assign fits    = rem2 >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      valid <= 1'b0;
      cnt   <= '0;
    end else if (start) begin
      busy    <= 1'b1;
      valid   <= 1'b0;
      cnt     <= '0;
      divisor <= D_W'(tau_eff) + D_W'(dt);
      rem     <= D_W'(dt);
    end else if (busy) begin
      // remainder stays below the divisor, so it fits D_W bits after subtract
      rem   <= fits ? D_W'(rem2 - {1'b0, divisor}) : D_W'(rem2);
      alpha <= {alpha[ALPHA_W-2:0], fits};
      cnt   <= cnt + CNT_W'(1);
      if (cnt == CNT_LAST) begin
        busy  <= 1'b0;
        valid <= 1'b1;
      end
    end
  end

endmodule

@@ design/imu_cf_lane.sv @@
// One axis lane: scale, offset, gain with saturation and the low-pass update,
// all through one shared bit-serial multiplier. Uses imu_cf_pkg and imu_cf_mul.
module imu_cf_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  imu_cf_pkg::lane_ctrl_t              ctl,
  input  logic [imu_cf_pkg::ALPHA_W-1:0]      alpha,
  input  logic signed [imu_cf_pkg::RAW_W-1:0] raw,
  input  logic [imu_cf_pkg::SCALE_W-1:0]      scale,
  input  logic signed [imu_cf_pkg::OFFS_W-1:0] offset,
  input  logic signed [imu_cf_pkg::GAIN_W-1:0] gain,
  output logic                                done,
  output logic signed [imu_cf_pkg::OUT_W-1:0] filt
);
  import imu_cf_pkg::*;

  localparam int P_W = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL1, S_LOAD2, S_MUL2, S_WAIT_A, S_MUL3, S_DONE
  } state_t;

  state_t state;

  logic                      mul_start;
  logic                      mul_done;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [P_W-1:0]     p;
  logic signed [P_W-1:0]     p_rnd8;
  logic signed [P_W-1:0]     p_rnd16;
  logic signed [32:0]        scaled;
  logic signed [MUL_A_W-1:0] sum_next;
  logic signed [MUL_A_W-1:0] sum;
  logic signed [42:0]        t;
  logic signed [OUT_W-1:0]   u_next;
  logic signed [OUT_W-1:0]   u;
  logic signed [OUT_W:0]     diff;
  logic signed [OUT_W:0]     filt_sum;

  imu_cf_mul #(.A_W(MUL_A_W), .B_W(MUL_B_W)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (p)
  );

  assign diff = (OUT_W+1)'(u) - (OUT_W+1)'(filt);

  always_comb begin
    mul_start = 1'b0;
    mul_a     = MUL_A_W'(raw);
    mul_b     = MUL_B_W'({1'b0, scale});
    unique case (state)
      S_IDLE: begin
        mul_start = ctl.start;
      end
      S_LOAD2: begin
        mul_start = 1'b1;
        mul_a     = sum;
        mul_b     = MUL_B_W'(gain);
      end
      S_WAIT_A: begin
        mul_start = ctl.alpha_ok;
        mul_a     = MUL_A_W'(diff);
        mul_b     = MUL_B_W'({1'b0, alpha});
      end
      default: begin
      end
    endcase
  end

  // round half up, then drop the fraction bits
  assign p_rnd8   = p + P_W'(128);
  assign p_rnd16  = p + P_W'(32768);
  assign scaled   = p_rnd8[40:8];
  assign sum_next = MUL_A_W'(scaled) + MUL_A_W'(offset);
  assign t        = p_rnd16[58:16];
  assign filt_sum = (OUT_W+1)'(filt) + p_rnd16[48:16];

  always_comb begin
    if (t[42:31] == {12{t[42]}}) begin
      u_next = t[31:0];
    end else begin
      u_next = t[42] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      filt  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (ctl.start) state <= S_MUL1;
        end
        S_MUL1: begin
          if (mul_done) begin
            sum   <= sum_next;
            state <= S_LOAD2;
          end
        end
        S_LOAD2: begin
          state <= S_MUL2;
        end
        S_MUL2: begin
          if (mul_done) begin
            u     <= u_next;
            state <= S_WAIT_A;
          end
        end
        S_WAIT_A: begin
          if (ctl.alpha_ok) state <= S_MUL3;
        end
        S_MUL3: begin
          if (mul_done) begin
            // the update lies between old and target, so the low word is exact
            filt  <= filt_sum[OUT_W-1:0];
            done  <= 1'b1;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (ctl.ack) begin
            done  <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ design/imu_axis_conditioning_filter_core.sv @@
// Top level of the IMU axis conditioning filter: register file, sample
// sequencer, alpha divider and three axis lanes. Uses imu_cf_pkg and imu_cf_if.
//
// Each accepted sample beat yields one result beat: every axis lane runs three
// bit-serial multiplies in turn (scale, gain, filter update), and the three
// lanes run side by side; the alpha divider overlaps the first multiply. One
// sample is in work at a time; a new sample is taken as soon as the previous
// result has moved into the output register, even while that result still
// waits on the sink. Configuration beats are always taken and must arrive while
// no sample is in work. Register indexes past the last register are ignored.
module imu_axis_conditioning_filter_core #(
  parameter int OVERLOAD_LIMIT = imu_cf_pkg::OVERLOAD_LIMIT_DEF
) (
  input  logic         clk,
  input  logic         rst,
  imu_cf_in_if.sink    samples,
  imu_cf_out_if.source results,
  imu_cf_cfg_if.sink   cfg
);
  import imu_cf_pkg::*;

  localparam logic signed [RAW_W:0] LIM_POS = (RAW_W+1)'(OVERLOAD_LIMIT);
  localparam logic signed [RAW_W:0] LIM_NEG = -(RAW_W+1)'(OVERLOAD_LIMIT);

  typedef enum logic {S_IDLE, S_BUSY} state_t;

  state_t state;

  logic [TAU_W-1:0]         tau;
  logic [SCALE_W-1:0]       scale;
  logic signed [OFFS_W-1:0] offset_x, offset_y, offset_z;
  logic signed [GAIN_W-1:0] gain_x, gain_y, gain_z;

  logic [TS_W-1:0]          last_time;
  logic signed [RAW_W-1:0]  raw_x, raw_y, raw_z;
  logic                     overload;
  logic                     ovl_next;
  logic                     accept;
  logic                     lanes_start;
  logic                     all_done;
  logic                     out_free;
  logic                     div_valid;
  logic [ALPHA_W-1:0]       alpha;
  logic [TS_W-1:0]          dt;
  lane_ctrl_t               lane_ctl;
  logic [2:0]               lane_done;
  logic signed [OUT_W-1:0]  filt_x, filt_y, filt_z;

  logic                     out_valid;
  logic signed [OUT_W-1:0]  out_x, out_y, out_z;
  logic                     out_ovl;

  function automatic logic over(input logic signed [RAW_W-1:0] r);
    logic signed [RAW_W:0] rx;
    rx = (RAW_W+1)'(r);
    return (rx >= LIM_POS) || (rx <= LIM_NEG);
  endfunction

  assign samples.ready = (state == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign dt            = samples.timestamp_us - last_time;
  assign ovl_next      = over(samples.raw_x) || over(samples.raw_y) || over(samples.raw_z);

  assign all_done = &lane_done;
  assign out_free = !out_valid || results.ready;

  assign lane_ctl.start    = lanes_start;
  assign lane_ctl.alpha_ok = div_valid;
  assign lane_ctl.ack      = (state == S_BUSY) && all_done && out_free;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tau      <= TAU_RST;
      scale    <= SCALE_RST;
      offset_x <= '0;
      offset_y <= '0;
      offset_z <= '0;
      gain_x   <= GAIN_RST;
      gain_y   <= GAIN_RST;
      gain_z   <= GAIN_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_TAU:      tau      <= cfg.data;
        REG_SCALE:    scale    <= cfg.data[SCALE_W-1:0];
        REG_OFFSET_X: offset_x <= cfg.data;
        REG_OFFSET_Y: offset_y <= cfg.data;
        REG_OFFSET_Z: offset_z <= cfg.data;
        REG_GAIN_X:   gain_x   <= cfg.data[GAIN_W-1:0];
        REG_GAIN_Y:   gain_y   <= cfg.data[GAIN_W-1:0];
        REG_GAIN_Z:   gain_z   <= cfg.data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      last_time   <= '0;
      lanes_start <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      lanes_start <= accept;
      // load a finished result, else drop the beat the sink has taken
      if (lane_ctl.ack) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            raw_x       <= samples.raw_x;
            raw_y       <= samples.raw_y;
            raw_z       <= samples.raw_z;
            overload    <= ovl_next;
            last_time   <= samples.timestamp_us;
            state       <= S_BUSY;
          end
        end
        S_BUSY: begin
          if (lane_ctl.ack) begin
            out_x     <= filt_x;
            out_y     <= filt_y;
            out_z     <= filt_z;
            out_ovl   <= overload;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid          = out_valid;
  assign results.filtered_out_x = out_x;
  assign results.filtered_out_y = out_y;
  assign results.filtered_out_z = out_z;
  assign results.overload       = out_ovl;

  imu_cf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .dt    (dt),
    .tau   (tau),
    .valid (div_valid),
    .alpha (alpha)
  );

  imu_cf_lane u_lane_x (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .alpha  (alpha),
    .raw    (raw_x),
    .scale  (scale),
    .offset (offset_x),
    .gain   (gain_x),
    .done   (lane_done[0]),
    .filt   (filt_x)
  );

  imu_cf_lane u_lane_y (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .alpha  (alpha),
    .raw    (raw_y),
    .scale  (scale),
    .offset (offset_y),
    .gain   (gain_y),
    .done   (lane_done[1]),
    .filt   (filt_y)
  );

  imu_cf_lane u_lane_z (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .alpha  (alpha),
    .raw    (raw_z),
    .scale  (scale),
    .offset (offset_z),
    .gain   (gain_z),
    .done   (lane_done[2]),
    .filt   (filt_z)
  );

  a_ack_all_done: assert property (@(posedge clk) disable iff (rst)
    lane_ctl.ack |-> all_done)
    else $error("lane ack before all lanes finished");

  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    accept |=> !samples.ready)
    else $error("second sample taken while one is in work");

  a_ack_loads_out: assert property (@(posedge clk) disable iff (rst)
    lane_ctl.ack |=> results.valid)
    else $error("finished result did not reach the output register");

  a_start_idle_lanes: assert property (@(posedge clk) disable iff (rst)
    lanes_start |-> (lane_done == 3'b000))
    else $error("lanes started while holding an unreleased result");

endmodule

@@ verif/testbench.sv @@
// Self-checking bench for imu_axis_conditioning_filter_core: drives samples with random gaps and
// register writes in bursts, predicts every filtered result and checks each output beat.
// Depends on imu_cf_pkg and the imu_cf_in_if, imu_cf_out_if and imu_cf_cfg_if interfaces.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import imu_cf_pkg::*;

  localparam int     AXES        = 3;
  localparam int     QUIET_LIMIT = 4000;
  localparam longint S32_MAX     = 64'sd2147483647;
  localparam longint S32_MIN     = -64'sd2147483648;

  typedef struct {
    logic [TS_W-1:0]         ts;
    logic signed [RAW_W-1:0] raw [AXES];
  } sample_t;

  typedef struct {
    logic signed [OUT_W-1:0] level [AXES];
    logic                    overload;
  } result_t;

  class conditioning_board;
    logic [TAU_W-1:0]         tau_us    = TAU_RST;
    logic [SCALE_W-1:0]       scale_rcp = SCALE_RST;
    logic signed [OFFS_W-1:0] offset [AXES] = '{default: '0};
    logic signed [GAIN_W-1:0] gain [AXES]   = '{default: GAIN_RST};
    logic [TS_W-1:0]          last_ts = '0;
    logic signed [OUT_W-1:0]  level [AXES]  = '{default: '0};
    result_t                  due_outputs [$];
    int                       errors = 0;

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] word);
      case (idx)
        REG_TAU:      tau_us    = word;
        REG_SCALE:    scale_rcp = word[SCALE_W-1:0];
        REG_OFFSET_X: offset[0] = word;
        REG_OFFSET_Y: offset[1] = word;
        REG_OFFSET_Z: offset[2] = word;
        REG_GAIN_X:   gain[0]   = word[GAIN_W-1:0];
        REG_GAIN_Y:   gain[1]   = word[GAIN_W-1:0];
        REG_GAIN_Z:   gain[2]   = word[GAIN_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_half_up(longint v, int n);
      return (v + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function logic signed [OUT_W-1:0] next_level(logic signed [RAW_W-1:0] raw,
                                                 logic signed [OFFS_W-1:0] offs,
                                                 logic signed [GAIN_W-1:0] g,
                                                 longint alpha,
                                                 logic signed [OUT_W-1:0] old);
      longint scaled, corrected, u, step;
      scaled    = round_half_up(longint'(raw) * longint'(scale_rcp), 8);
      corrected = round_half_up((scaled + longint'(offs)) * longint'(g), 16);
      if (corrected > S32_MAX) u = S32_MAX;
      else if (corrected < S32_MIN) u = S32_MIN;
      else u = corrected;
      step = round_half_up(alpha * (u - longint'(old)), 16);
      return OUT_W'(longint'(old) + step);
    endfunction

    function void note_sample(sample_t s);
      result_t         r;
      logic [TS_W-1:0] dt;
      longint unsigned span, denom;
      longint          alpha;
      dt    = s.ts - last_ts;
      span  = {32'b0, dt};
      // a zero time constant behaves as one microsecond
      denom = (tau_us == '0) ? 64'd1 : {32'b0, tau_us};
      alpha = longint'((span << ALPHA_W) / (denom + span));
      last_ts = s.ts;
      r.overload = 1'b0;
      for (int a = 0; a < AXES; a++) begin
        if (s.raw[a] >= OVERLOAD_LIMIT_DEF || s.raw[a] <= -OVERLOAD_LIMIT_DEF)
          r.overload = 1'b1;
        level[a]   = next_level(s.raw[a], offset[a], gain[a], alpha, level[a]);
        r.level[a] = level[a];
      end
      due_outputs.push_back(r);
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_result(result_t got);
      result_t want;
      if (due_outputs.size() == 0) begin
        report($sformatf("output beat with no sample outstanding (x=%0d y=%0d z=%0d)",
                         got.level[0], got.level[1], got.level[2]));
        return;
      end
      want = due_outputs.pop_front();
      for (int a = 0; a < AXES; a++)
        if (got.level[a] !== want.level[a])
          report($sformatf("filtered_out_%s got %0d expected %0d",
                           a == 0 ? "x" : (a == 1 ? "y" : "z"), got.level[a], want.level[a]));
      if (got.overload !== want.overload)
        report($sformatf("overload got %b expected %b", got.overload, want.overload));
    endtask

    function int pending();
      return due_outputs.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  imu_cf_in_if  sample_bus ();
  imu_cf_out_if result_bus ();
  imu_cf_cfg_if cfg_bus ();

  imu_axis_conditioning_filter_core dut (
    .clk     (clk),
    .rst     (rst),
    .samples (sample_bus),
    .results (result_bus),
    .cfg     (cfg_bus)
  );

  conditioning_board     board = new();
  logic [TS_W-1:0]       cur_ts = '0;
  logic [CFG_IDX_W-1:0]  reg_index [8];
  logic [CFG_DATA_W-1:0] reg_plan [8];
  bit                    calm = 1'b0;
  int                    quiet_cycles = 0;
  result_t               seen;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [RAW_W-1:0] random_raw();
    int r, v;
    r = $urandom_range(0, 99);
    if (r < 5) return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
    if (r < 15) begin
      v = $urandom_range(31995, 32767);
      return RAW_W'($urandom_range(0, 1) ? v : -v);
    end
    if (r < 60) return RAW_W'(int'($urandom_range(0, 4000)) - 2000);
    return RAW_W'($urandom());
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    int      r;
    r = $urandom_range(0, 99);
    // below 8 keep the timestamp: zero interval
    if (r >= 90) cur_ts += $urandom();
    else if (r >= 70) cur_ts += $urandom_range(3001, 200000);
    else if (r >= 8) cur_ts += $urandom_range(1, 3000);
    s.ts = cur_ts;
    for (int a = 0; a < AXES; a++) s.raw[a] = random_raw();
    return s;
  endfunction

  function automatic void randomize_registers();
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 3) reg_plan[0] = $urandom_range(0, 100);
    else if (r < 7) reg_plan[0] = $urandom_range(1000, 50000);
    else reg_plan[0] = $urandom();
    reg_plan[1] = $urandom_range(0, 1) ? CFG_DATA_W'($urandom_range(400000, 600000))
                                       : CFG_DATA_W'($urandom());
    for (int a = 0; a < AXES; a++) begin
      reg_plan[2 + a] = $urandom_range(0, 1) ? CFG_DATA_W'(int'($urandom_range(0, 4194304)) - 2097152)
                                             : CFG_DATA_W'($urandom());
      v = $urandom_range(0, 131072);
      if ($urandom_range(0, 4) == 0) v = -v;
      reg_plan[5 + a] = ($urandom_range(0, 9) < 7) ? CFG_DATA_W'(v) : CFG_DATA_W'($urandom());
    end
  endfunction

  // Keep valid high across the whole burst, then one write to an unused index.
  task automatic program_registers();
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] word;
    for (int i = 0; i <= 8; i++) begin
      if (i < 8) begin
        idx  = reg_index[i];
        word = reg_plan[i];
      end else begin
        idx  = REG_GAIN_Z + CFG_IDX_W'($urandom_range(1, 8));
        word = $urandom();
      end
      cfg_bus.valid <= 1'b1;
      cfg_bus.index <= idx;
      cfg_bus.data  <= word;
      @(posedge clk);
      while (!cfg_bus.ready) @(posedge clk);
      board.set_register(idx, word);
    end
    cfg_bus.valid <= 1'b0;
  endtask

  // Valid stays high from the previous beat unless a gap is taken.
  task automatic push_sample(input sample_t s);
    int gap;
    gap = calm ? 0 : pick_gap();
    if (gap > 0) begin
      sample_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_bus.valid        <= 1'b1;
    sample_bus.timestamp_us <= s.ts;
    sample_bus.raw_x        <= s.raw[0];
    sample_bus.raw_y        <= s.raw[1];
    sample_bus.raw_z        <= s.raw[2];
    @(posedge clk);
    while (!sample_bus.ready) @(posedge clk);
    board.note_sample(s);
  endtask

  task automatic push_at(input logic [TS_W-1:0] ts, input int x, input int y, input int z);
    sample_t s;
    cur_ts   = ts;
    s.ts     = ts;
    s.raw[0] = RAW_W'(x);
    s.raw[1] = RAW_W'(y);
    s.raw[2] = RAW_W'(z);
    push_sample(s);
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain_results();
    sample_bus.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Sink: runs of ready, broken by stalls; an occasional long run with no stall.
  initial begin
    int run, stall;
    result_bus.ready = 1'b0;
    @(posedge clk);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 8);
      result_bus.ready <= 1'b1;
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        result_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_bus.valid && result_bus.ready) begin
      seen.level[0] = result_bus.filtered_out_x;
      seen.level[1] = result_bus.filtered_out_y;
      seen.level[2] = result_bus.filtered_out_z;
      seen.overload = result_bus.overload;
      board.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_bus.valid && sample_bus.ready) || (result_bus.valid && result_bus.ready)
        || (cfg_bus.valid && cfg_bus.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    sample_bus.valid        = 1'b0;
    sample_bus.timestamp_us = '0;
    sample_bus.raw_x        = '0;
    sample_bus.raw_y        = '0;
    sample_bus.raw_z        = '0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.index           = REG_TAU;
    cfg_bus.data            = '0;
    reg_index = '{REG_TAU, REG_SCALE, REG_OFFSET_X, REG_OFFSET_Y, REG_OFFSET_Z,
                  REG_GAIN_X, REG_GAIN_Y, REG_GAIN_Z};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: first beat at time zero, axis extremes, overload edges, wrap.
    push_at(32'd0, 0, 0, 0);
    push_at(32'd1000, 32767, -32768, 0);
    push_at(32'd2000, 31999, -31999, 1);
    push_at(32'd2500, 32000, 0, -1);
    push_at(32'd2500, 0, -32000, 0);
    push_at(32'd3000, 0, 0, 32000);
    push_at(32'd3001, -32768, -32768, -32768);
    push_at(32'hFFFF_FF00, 12345, -12345, 500);
    push_at(32'h0000_0200, 200, -200, 300);
    push_at(32'h0000_0400, 0, 0, 0);

    // Upper extremes of scale, offset and gain with a one-microsecond time constant: gain products clip high.
    drain_results();
    reg_plan = '{32'd1, 32'h00FF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                 32'h007F_FFFF, 32'h007F_FFFF, 32'h007F_FFFF};
    program_registers();
    push_at(cur_ts + 1000, 32767, 32767, 32767);
    push_at(cur_ts + 1000, -32768, -32768, -32768);
    push_at(cur_ts, 0, 0, 0);

    // Lower extremes: zero time constant, zero scale, most negative offset and gain.
    drain_results();
    reg_plan = '{32'd0, 32'd0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h0080_0000, 32'h0080_0000, 32'h0080_0000};
    program_registers();
    push_at(cur_ts + 5, 1, -1, 0);
    push_at(cur_ts + 100000, 32767, -32768, 0);
    push_at(cur_ts + 1, 0, 0, 0);

    // Longest time constant against the longest interval.
    drain_results();
    reg_plan = '{32'hFFFF_FFFF, 32'd511501, 32'hFFFF_0000, 32'h0001_0000, 32'd0,
                 32'hFFFF_0000, 32'h0002_0000, 32'h007F_FFFF};
    program_registers();
    push_at(cur_ts - 1, 20000, -20000, 32767);
    push_at(cur_ts + 7, -5, 5, -32768);

    for (int p = 0; p < 8; p++) begin
      drain_results();
      randomize_registers();
      program_registers();
      calm = ($urandom_range(0, 3) == 0);
      repeat (90) push_sample(random_sample());
    end

    drain_results();
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
design/imu_cf_pkg.sv
design/imu_cf_if.sv
design/imu_cf_mul.sv
design/imu_cf_div.sv
design/imu_cf_lane.sv
design/imu_axis_conditioning_filter_core.sv
verif/testbench.sv
